// ----- design/ihex_pkg.sv -----
// Shared types and constants for the Intel HEX record encoder.
// No dependencies; imported by ihex_ctrl, ihex_dp and the top level.
package ihex_pkg;

  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_EOF   = 8'h01;
  localparam logic [7:0] TYPE_EXT   = 8'h04;
  localparam logic [7:0] BLANK_BYTE = 8'hFF;
  localparam logic [7:0] EXT_COUNT  = 8'h02;
  localparam logic [7:0] EOF_COUNT  = 8'h00;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EXT  = 2'd1,
    KIND_EOF  = 2'd2
  } rec_kind_t;

  // records still owed for the current input item
  typedef struct packed {
    logic data;
    logic ext;
    logic eof;
  } pend_t;

  typedef struct packed {
    logic      accept;
    logic      start;
    rec_kind_t kind;
    logic      emit;
    logic      run_done;
  } dp_cmd_t;

  typedef struct packed {
    logic  slot_free;
    logic  at_csum;
    pend_t pend;
  } dp_stat_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = 7'h30 + {3'b000, nib};
    end else begin
      ch = 7'h41 + {3'b000, nib} - 7'd10;
    end
    return ch;
  endfunction

endpackage

// ----- design/ihex_ctrl.sv -----
// Sequencer for the Intel HEX encoder: takes items, then walks the owed records.
// Depends on ihex_pkg; drives ihex_dp through dp_cmd_t and reads dp_stat_t.
module ihex_ctrl import ihex_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PICK = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  pend_t  pend_r, pend_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.kind  = KIND_EOF;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          pend_nxt   = stat.pend;
          if (stat.pend != '0) begin
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        cmd.start = 1'b1;
        if (pend_r.data) begin
          cmd.kind      = KIND_DATA;
          pend_nxt.data = 1'b0;
        end else if (pend_r.ext) begin
          cmd.kind     = KIND_EXT;
          pend_nxt.ext = 1'b0;
        end else begin
          cmd.kind     = KIND_EOF;
          pend_nxt.eof = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.run_done = (pend_r == '0);
          if (stat.at_csum) begin
            state_nxt = (pend_r == '0) ? S_IDLE : S_PICK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && stat.slot_free && stat.at_csum && pend_r == '0)
      |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after last record");

  a_pick_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> (pend_r != '0))
    else $error("record pick with nothing pending");

endmodule

// ----- design/ihex_dp.sv -----
// Datapath for the Intel HEX encoder: record buffer, address/offset state,
// byte mux, checksum and output register. Depends on ihex_pkg.
module ihex_dp import ihex_pkg::*; #(
  parameter int RECORD_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_byte,
  input  logic       in_end_of_image,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [6:0] out_hex_high_char,
  output logic [6:0] out_hex_low_char,
  output logic       out_starts_record,
  output logic       out_ends_record,
  output logic       out_last_of_run
);

  localparam int FILL_W = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int POS_W  = $clog2(RECORD_BYTES + 6);

  logic              skip_blank_r;
  logic [FILL_W-1:0] fill_r;
  logic [15:0]       addr_r;
  logic [15:0]       upper_r;
  logic              blank_r;
  logic [7:0]        buf_r [RECORD_BYTES];

  logic [15:0]       lat_addr_r;
  logic [FILL_W-1:0] lat_len_r;
  logic [15:0]       lat_upper_r;

  rec_kind_t         kind_r;
  logic [POS_W-1:0]  pos_r;
  logic [7:0]        sum_r;

  logic              out_valid_r;
  logic [6:0]        out_hi_r, out_lo_r;
  logic              out_start_r, out_end_r, out_last_r;

  // item intake
  logic              wr;
  logic [FILL_W-1:0] fill_after;
  logic              blank_after;
  logic              full;
  logic [16:0]       addr_sum;
  logic              page_end;
  logic              short_rec;

  assign wr          = in_has_byte && (fill_r < FILL_W'(RECORD_BYTES));
  assign fill_after  = fill_r + FILL_W'(wr);
  assign blank_after = blank_r & (!wr || (in_data_byte == BLANK_BYTE));
  assign full        = wr && (fill_after == FILL_W'(RECORD_BYTES));
  assign addr_sum    = {1'b0, addr_r} + 17'(RECORD_BYTES);
  assign page_end    = addr_sum[16];
  assign short_rec   = in_end_of_image && !full && (fill_after != '0);

  // record byte sequencing
  logic [7:0]       rec_count;
  logic [15:0]      rec_addr;
  logic [7:0]       rec_type;
  logic [POS_W-1:0] csum_pos;
  logic             at_csum;
  logic [IDX_W-1:0] data_idx;
  logic [POS_W-1:0] pos_off;
  logic [7:0]       cur_byte;
  logic             slot_free;

  always_comb begin
    case (kind_r)
      KIND_DATA: begin
        rec_count = 8'(lat_len_r);
        rec_addr  = lat_addr_r;
        rec_type  = TYPE_DATA;
      end
      KIND_EXT: begin
        rec_count = EXT_COUNT;
        rec_addr  = 16'h0000;
        rec_type  = TYPE_EXT;
      end
      default: begin
        rec_count = EOF_COUNT;
        rec_addr  = 16'h0000;
        rec_type  = TYPE_EOF;
      end
    endcase
  end

  assign csum_pos  = POS_W'(rec_count) + POS_W'(4);
  assign at_csum   = (pos_r == csum_pos);
  assign pos_off   = pos_r - POS_W'(4);
  assign data_idx  = pos_off[IDX_W-1:0];
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    if (at_csum) begin
      cur_byte = 8'h00 - sum_r;
    end else if (pos_r == POS_W'(0)) begin
      cur_byte = rec_count;
    end else if (pos_r == POS_W'(1)) begin
      cur_byte = rec_addr[15:8];
    end else if (pos_r == POS_W'(2)) begin
      cur_byte = rec_addr[7:0];
    end else if (pos_r == POS_W'(3)) begin
      cur_byte = rec_type;
    end else if (kind_r == KIND_EXT) begin
      cur_byte = pos_r[0] ? lat_upper_r[7:0] : lat_upper_r[15:8];
    end else begin
      cur_byte = buf_r[data_idx];
    end
  end

  always_comb begin
    stat           = '0;
    stat.slot_free = slot_free;
    stat.at_csum   = at_csum;
    stat.pend.data = (full && !(skip_blank_r && blank_after)) || short_rec;
    stat.pend.ext  = full && page_end;
    stat.pend.eof  = in_end_of_image;
  end

  // buffer has no reset; only entries below the latched length are read
  always_ff @(posedge clk) begin
    if (cmd.accept && wr) begin
      buf_r[fill_r[IDX_W-1:0]] <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_blank_r <= 1'b0;
      fill_r       <= '0;
      addr_r       <= 16'h0000;
      upper_r      <= 16'h0001;
      blank_r      <= 1'b1;
      kind_r       <= KIND_EOF;
      pos_r        <= '0;
      sum_r        <= 8'h00;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        skip_blank_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (in_end_of_image) begin
          fill_r  <= '0;
          addr_r  <= 16'h0000;
          upper_r <= 16'h0001;
          blank_r <= 1'b1;
        end else begin
          fill_r  <= full ? '0 : fill_after;
          blank_r <= full ? 1'b1 : blank_after;
          addr_r  <= full ? addr_sum[15:0] : addr_r;
          upper_r <= (full && page_end) ? (upper_r + 16'h0001) : upper_r;
        end
      end
      if (cmd.start) begin
        kind_r <= cmd.kind;
        pos_r  <= '0;
        sum_r  <= 8'h00;
      end else if (cmd.emit) begin
        pos_r <= pos_r + POS_W'(1);
        sum_r <= sum_r + cur_byte;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-item snapshot used while the records go out, and the output character register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat_addr_r  <= addr_r;
      lat_len_r   <= full ? FILL_W'(RECORD_BYTES) : fill_after;
      lat_upper_r <= upper_r;
    end
    if (cmd.emit) begin
      out_hi_r    <= hex_char(cur_byte[7:4]);
      out_lo_r    <= hex_char(cur_byte[3:0]);
      out_start_r <= (pos_r == POS_W'(0));
      out_end_r   <= at_csum;
      out_last_r  <= at_csum && cmd.run_done;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hex_high_char = out_hi_r;
  assign out_hex_low_char  = out_lo_r;
  assign out_starts_record = out_start_r;
  assign out_ends_record   = out_end_r;
  assign out_last_of_run   = out_last_r;

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free)
    else $error("record byte emitted over an untaken transaction");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_end_r)
    else $error("run ended on a byte that is not a checksum");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(RECORD_BYTES))
    else $error("fill count reached record size outside a flush");

endmodule

// ----- design/intel_hex_record_encoder_top.sv -----
// Intel HEX record encoder top level: ihex_ctrl sequencer plus ihex_dp datapath.
// An item is taken while in_ready is high; its first record byte, if any, is valid
// in the output register after S_PICK and S_EMIT. Each record is set up in S_PICK,
// then sends count + 5 bytes, one per cycle while the output slot is free; the
// output register paces the byte stream. An item with no record leaves ctrl idle.
// Reset (rst_n, synchronous): empty image, address 0, offset 1, skip_blank 0.
module intel_hex_record_encoder_top import ihex_pkg::*; #(
  parameter int RECORD_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_has_byte,
  input  logic       in_end_of_image,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_hex_high_char,
  output logic [6:0] out_hex_low_char,
  output logic       out_starts_record,
  output logic       out_ends_record,
  output logic       out_last_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ihex_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ihex_dp #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_image   (in_end_of_image),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_hex_high_char (out_hex_high_char),
    .out_hex_low_char  (out_hex_low_char),
    .out_starts_record (out_starts_record),
    .out_ends_record   (out_ends_record),
    .out_last_of_run   (out_last_of_run)
  );

endmodule
